>>> hw/rtl/tnc2_pkg.sv
// Shared types and constants for the TNC2 to AX.25 frame encoder.
// No dependencies.
package tnc2_pkg;

    localparam int AddrWidth = 52;
    localparam logic [15:0] FcsInit = 16'hFFFF;
    localparam logic [15:0] FcsPoly = 16'h8408;
    localparam logic [7:0] CtrlUi = 8'h03;
    localparam logic [7:0] PidNone = 8'hF0;
    localparam logic [7:0] SsidBase = 8'h60;
    localparam logic [7:0] CBit = 8'h80;

    // Parse phases of one line.
    typedef enum logic [2:0] {
        PH_SOURCE = 3'd0,
        PH_DEST = 3'd1,
        PH_PATH = 3'd2,
        PH_INFO = 3'd3,
        PH_REJECT = 3'd4
    } phase_t;

    // SSID parse modes.
    typedef enum logic [1:0] {
        SM_BEFORE = 2'd0,
        SM_LEAD = 2'd1,
        SM_DIGITS = 2'd2,
        SM_DONE = 2'd3
    } ssid_mode_t;

    // One CRC-16/X.25 byte update, eight bit steps on a narrow value.
    function automatic logic [15:0] fcs_byte(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] f;
        f = fcs;
        for (int i = 0; i < 8; i++) begin
            if (f[0] ^ b[i]) begin
                f = (f >> 1) ^ FcsPoly;
            end else begin
                f = f >> 1;
            end
        end
        return f;
    endfunction

endpackage

>>> hw/rtl/tnc2_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tnc2_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/tnc2_to_ax25_frame_encoder_top.sv
// Top level of the TNC2 to AX.25 UI frame encoder.
// Depends on tnc2_pkg and tnc2_ram.
//
//  channel | signals                                  | direction
//  input   | in_valid, in_ready, char_in, end_of_line | into block
//  output  | out_valid, out_ready, frame_byte,        | out of block
//          | frame_end, rejected                      |
//
// A character that gives no byte is simply consumed; each result byte passes
// through the single output register and is held there while out_ready is low.
// The header burst reads one address word from the RAM per address, in state
// S_RD ahead of its seven bytes, then sends the control and PID bytes.
// Reset clears all control state; the address RAM is not cleared, since
// only entries written on the current line are read.
// Input is taken only when no burst is running and the output register is free.
module tnc2_to_ax25_frame_encoder_top
    import tnc2_pkg::*;
#(
    parameter int MAX_PATH = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] frame_byte,
    output logic       frame_end,
    output logic       rejected
);
    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_ADDR = 6'b000100,
        S_CTRL = 6'b001000,
        S_TAIL = 6'b010000,
        S_FCS  = 6'b100000
    } seq_t;

    seq_t       seq_reg, seq_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] pcnt_reg, pcnt_next;
    logic [7:0] ch_reg [6];
    logic [7:0] ch_next [6];
    logic [2:0] ccnt_reg, ccnt_next;
    logic       nonempty_reg, nonempty_next;
    ssid_mode_t sm_reg, sm_next;
    logic       neg_reg, neg_next;
    logic [3:0] ssid_reg, ssid_next;
    logic [15:0] fcs_reg, fcs_next;
    // Burst control: address index, byte index, FCS tail flag.
    logic [2:0] aidx_reg, aidx_next;
    logic [2:0] bidx_reg, bidx_next;
    logic       tail_reg, tail_next;
    logic       ctrl_pid_reg, ctrl_pid_next;
    // Output register.
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic       oe_reg, oe_next;
    logic       orj_reg, orj_next;

    logic                 we;
    logic [2:0]           waddr, raddr;
    logic [AddrWidth-1:0] wdata, rdata;

    tnc2_ram #(.Width(AddrWidth), .Depth(8)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic oslot;
    assign oslot = !ov_reg || out_ready;
    assign in_ready = (seq_reg == S_IDLE) && oslot;
    assign out_valid = ov_reg;
    assign frame_byte = ob_reg;
    assign frame_end = oe_reg;
    assign rejected = orj_reg;

    logic [AddrWidth-1:0] elem_word;
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            elem_word[8*i +: 8] = ch_reg[i];
        end
        elem_word[51:48] = neg_reg ? 4'd0 : ssid_reg;
    end

    logic [7:0] addr_byte;
    logic       addr_last;
    logic [2:0] last_idx;
    assign last_idx = (pcnt_reg == 3'd0) ? 3'd1 : pcnt_reg + 3'd1;
    // Address indices: 0 destination, 1 source, 2.. path.
    assign addr_last = (aidx_reg == last_idx);
    always_comb
    begin
        if (bidx_reg == 3'd6)
        begin
            addr_byte = SsidBase | {3'd0, rdata[51:48], 1'b0} | {7'd0, addr_last}
                      | ((aidx_reg == 3'd0) ? CBit : 8'd0);
        end
        else
        begin
            addr_byte = {rdata[8*bidx_reg +: 7], 1'b0};
        end
    end

    logic c_digit, c_space;
    logic [7:0] c;
    assign c = char_in;
    assign c_digit = (c >= "0") && (c <= "9");
    assign c_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));

    logic [7:0] v10;
    logic go;

    always_comb
    begin
        seq_next = seq_reg;
        phase_next = phase_reg;
        pcnt_next = pcnt_reg;
        ch_next = ch_reg;
        ccnt_next = ccnt_reg;
        nonempty_next = nonempty_reg;
        sm_next = sm_reg;
        neg_next = neg_reg;
        ssid_next = ssid_reg;
        fcs_next = fcs_reg;
        aidx_next = aidx_reg;
        bidx_next = bidx_reg;
        tail_next = tail_reg;
        ctrl_pid_next = ctrl_pid_reg;
        ov_next = ov_reg && !out_ready;
        ob_next = ob_reg;
        oe_next = oe_reg;
        orj_next = orj_reg;
        we = 1'b0;
        waddr = 3'd0;
        wdata = elem_word;
        raddr = aidx_reg;
        v10 = 8'd0;
        go = 1'b0;

        case (seq_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (phase_reg)
                        PH_INFO:
                        begin
                            ov_next = 1'b1;
                            ob_next = c;
                            oe_next = 1'b0;
                            orj_next = 1'b0;
                            fcs_next = fcs_byte(fcs_reg, c);
                            if (end_of_line)
                            begin
                                seq_next = S_FCS;
                                bidx_next = 3'd0;
                            end
                        end
                        PH_REJECT:
                        begin
                        end
                        default:
                        begin
                            // Delimiters end an element.
                            if (phase_reg == PH_SOURCE && c == ">")
                            begin
                                if (!nonempty_reg) phase_next = PH_REJECT;
                                else
                                begin
                                    we = 1'b1; waddr = 3'd1; phase_next = PH_DEST;
                                end
                                go = 1'b1;
                            end
                            else if (phase_reg == PH_DEST && (c == "," || c == ":"))
                            begin
                                if (!nonempty_reg) phase_next = PH_REJECT;
                                else
                                begin
                                    we = 1'b1; waddr = 3'd0;
                                    if (c == ",") phase_next = PH_PATH;
                                    else
                                    begin
                                        phase_next = PH_INFO; seq_next = S_RD;
                                    end
                                end
                                go = 1'b1;
                            end
                            else if (phase_reg == PH_PATH && (c == "," || (c == ":" && nonempty_reg)))
                            begin
                                if (32'(pcnt_reg) >= MAX_PATH) phase_next = PH_REJECT;
                                else
                                begin
                                    we = 1'b1; waddr = pcnt_reg + 3'd2;
                                    pcnt_next = pcnt_reg + 3'd1;
                                    if (c == ":")
                                    begin
                                        phase_next = PH_INFO; seq_next = S_RD;
                                    end
                                end
                                go = 1'b1;
                            end
                            else if (phase_reg == PH_PATH && c == ":")
                            begin
                                phase_next = PH_INFO; seq_next = S_RD; go = 1'b1;
                            end
                            else
                            begin
                                // Character of an element.
                                nonempty_next = 1'b1;
                                case (sm_reg)
                                    SM_BEFORE:
                                    begin
                                        if (c == "-") sm_next = SM_LEAD;
                                        else if (ccnt_reg < 3'd6)
                                        begin
                                            ch_next[ccnt_reg] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                                            ccnt_next = ccnt_reg + 3'd1;
                                        end
                                    end
                                    SM_LEAD:
                                    begin
                                        if (c_space) sm_next = SM_LEAD;
                                        else if (c == "+") sm_next = SM_DIGITS;
                                        else if (c == "-")
                                        begin
                                            sm_next = SM_DIGITS; neg_next = 1'b1;
                                        end
                                        else if (c_digit)
                                        begin
                                            sm_next = SM_DIGITS; ssid_next = c[3:0];
                                        end
                                        else sm_next = SM_DONE;
                                    end
                                    SM_DIGITS:
                                    begin
                                        if (c_digit)
                                        begin
                                            v10 = {4'd0, ssid_reg} * 8'd10 + {4'd0, c[3:0]};
                                            ssid_next = (v10 > 8'd15) ? 4'd15 : v10[3:0];
                                        end
                                        else sm_next = SM_DONE;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            if (go)
                            begin
                                for (int i = 0; i < 6; i++) ch_next[i] = " ";
                                ccnt_next = 3'd0; nonempty_next = 1'b0;
                                sm_next = SM_BEFORE; neg_next = 1'b0; ssid_next = 4'd0;
                            end
                            aidx_next = 3'd0; bidx_next = 3'd0; ctrl_pid_next = 1'b0;
                            if (end_of_line && seq_next != S_RD)
                            begin
                                ov_next = 1'b1; ob_next = 8'd0; oe_next = 1'b1; orj_next = 1'b1;
                            end
                            else if (end_of_line)
                            begin
                                tail_next = 1'b1;
                            end
                        end
                    endcase
                    if (phase_reg == PH_REJECT && end_of_line)
                    begin
                        ov_next = 1'b1; ob_next = 8'd0; oe_next = 1'b1; orj_next = 1'b1;
                    end
                    // End of line returns the parser to reset.
                    if (end_of_line && seq_next == S_IDLE)
                    begin
                        phase_next = PH_SOURCE; pcnt_next = 3'd0;
                        for (int i = 0; i < 6; i++) ch_next[i] = " ";
                        ccnt_next = 3'd0; nonempty_next = 1'b0;
                        sm_next = SM_BEFORE; neg_next = 1'b0; ssid_next = 4'd0;
                        if (phase_reg != PH_INFO) fcs_next = FcsInit;
                    end
                    if (end_of_line && seq_next == S_RD) tail_next = 1'b1;
                    else tail_next = 1'b0;
                end
            end
            S_RD:
            begin
                // Address word read in flight.
                seq_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (oslot)
                begin
                    ov_next = 1'b1; ob_next = addr_byte; oe_next = 1'b0; orj_next = 1'b0;
                    fcs_next = fcs_byte(fcs_reg, addr_byte);
                    if (bidx_reg == 3'd6)
                    begin
                        bidx_next = 3'd0;
                        aidx_next = aidx_reg + 3'd1;
                        raddr = aidx_reg + 3'd1;
                        seq_next = addr_last ? S_CTRL : S_RD;
                    end
                    else bidx_next = bidx_reg + 3'd1;
                end
            end
            S_CTRL:
            begin
                if (oslot)
                begin
                    ov_next = 1'b1; oe_next = 1'b0; orj_next = 1'b0;
                    ob_next = ctrl_pid_reg ? PidNone : CtrlUi;
                    fcs_next = fcs_byte(fcs_reg, ctrl_pid_reg ? PidNone : CtrlUi);
                    ctrl_pid_next = 1'b1;
                    if (ctrl_pid_reg)
                    begin
                        seq_next = tail_reg ? S_FCS : S_IDLE;
                        bidx_next = 3'd0;
                    end
                end
            end
            S_FCS:
            begin
                if (oslot)
                begin
                    ov_next = 1'b1; orj_next = 1'b0;
                    ob_next = bidx_reg[0] ? ~fcs_reg[15:8] : ~fcs_reg[7:0];
                    oe_next = bidx_reg[0];
                    bidx_next = 3'd1;
                    if (bidx_reg[0])
                    begin
                        seq_next = S_IDLE;
                        phase_next = PH_SOURCE; pcnt_next = 3'd0; fcs_next = FcsInit;
                        tail_next = 1'b0;
                    end
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= S_IDLE;
            phase_reg <= PH_SOURCE;
            pcnt_reg <= 3'd0;
            for (int i = 0; i < 6; i++) ch_reg[i] <= " ";
            ccnt_reg <= 3'd0;
            nonempty_reg <= 1'b0;
            sm_reg <= SM_BEFORE;
            neg_reg <= 1'b0;
            ssid_reg <= 4'd0;
            fcs_reg <= FcsInit;
            aidx_reg <= 3'd0;
            bidx_reg <= 3'd0;
            tail_reg <= 1'b0;
            ctrl_pid_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            seq_reg <= seq_next;
            phase_reg <= phase_next;
            pcnt_reg <= pcnt_next;
            ch_reg <= ch_next;
            ccnt_reg <= ccnt_next;
            nonempty_reg <= nonempty_next;
            sm_reg <= sm_next;
            neg_reg <= neg_next;
            ssid_reg <= ssid_next;
            fcs_reg <= fcs_next;
            aidx_reg <= aidx_next;
            bidx_reg <= bidx_next;
            tail_reg <= tail_next;
            ctrl_pid_reg <= ctrl_pid_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        oe_reg <= oe_next;
        orj_reg <= orj_next;
    end

    // A rejected beat always ends its line.
    assert property (@(posedge clk) disable iff (!rst_n) ov_reg && orj_reg |-> oe_reg)
        else $error("rejected beat without frame_end");
    // Input is never taken during a header burst.
    assert property (@(posedge clk) disable iff (!rst_n) seq_reg != S_IDLE |-> !in_ready)
        else $error("input accepted during burst");
    // The path count never exceeds its limit.
    assert property (@(posedge clk) disable iff (!rst_n) 32'(pcnt_reg) <= MAX_PATH)
        else $error("path count overflow");
    // A read cycle is always followed by the address byte stage.
    assert property (@(posedge clk) disable iff (!rst_n) seq_reg == S_RD |=> seq_reg == S_ADDR)
        else $error("read latency slip");
endmodule

>>> tb/tb_frame_checker.sv
// Checker for the TNC2 to AX.25 frame encoder: watches both channels,
// predicts the frame bytes of each accepted character and compares them.
// Depends on tnc2_pkg for the phase and SSID mode types and the constants.
module tb_frame_checker
    import tnc2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_line,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       rejected,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxPathTb = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rej;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    // Shadow of the parser state.
    phase_t      phase;
    logic [51:0] addr_words[8];
    int          n_paths;
    logic [7:0]  elem[6];
    int          elem_len;
    logic        elem_used;
    ssid_mode_t  smode;
    logic        sneg;
    int          sval;
    logic [15:0] crc;

    assign pending_count = expected_beats.size();

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Appends one expected beat at the tail of the queue.
    task automatic queue_beat(input frame_beat_t b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic clear_elem();
        for (int i = 0; i < 6; i++) elem[i] = " ";
        elem_len = 0;
        elem_used = 0;
        smode = SM_BEFORE;
        sneg = 0;
        sval = 0;
    endtask

    task automatic clear_all();
        phase = PH_SOURCE;
        n_paths = 0;
        crc = FcsInit;
        clear_elem();
    endtask

    task automatic add_char(input logic [7:0] c);
        logic [7:0] u;
        elem_used = 1;
        case (smode)
            SM_BEFORE:
            begin
                if (c == "-") smode = SM_LEAD;
                else if (elem_len < 6)
                begin
                    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
                    elem[elem_len] = u;
                    elem_len++;
                end
            end
            SM_LEAD:
            begin
                if (c == " " || (c >= 8'd9 && c <= 8'd13)) ;
                else if (c == "+") smode = SM_DIGITS;
                else if (c == "-")
                begin
                    smode = SM_DIGITS;
                    sneg = 1;
                end
                else if (is_digit(c))
                begin
                    smode = SM_DIGITS;
                    sval = c - "0";
                end
                else smode = SM_DONE;
            end
            SM_DIGITS:
            begin
                if (is_digit(c))
                begin
                    sval = sval * 10 + (c - "0");
                    if (sval > 15) sval = 15;
                end
                else smode = SM_DONE;
            end
            default: ;
        endcase
    endtask

    function automatic logic [51:0] elem_addr();
        logic [51:0] w;
        for (int i = 0; i < 6; i++) w[8*i +: 8] = elem[i];
        w[51:48] = sneg ? 4'd0 : sval[3:0];
        return w;
    endfunction

    // Queues one frame byte and folds it into the running FCS.
    task automatic push_byte(input logic [7:0] b);
        queue_beat('{data: b, last: 1'b0, rej: 1'b0});
        for (int i = 0; i < 8; i++)
            crc = (crc[0] ^ b[i]) ? ((crc >> 1) ^ FcsPoly) : (crc >> 1);
    endtask

    task automatic push_addr(input logic [51:0] w, input logic fin, input logic cb);
        for (int i = 0; i < 6; i++) push_byte({w[8*i +: 7], 1'b0});
        push_byte(SsidBase | {3'b0, w[51:48], 1'b0} | {7'b0, fin} | (cb ? CBit : 8'h00));
    endtask

    task automatic push_header();
        push_addr(addr_words[0], 1'b0, 1'b1);
        push_addr(addr_words[1], n_paths == 0, 1'b0);
        for (int i = 0; i < n_paths; i++)
            push_addr(addr_words[2+i], i + 1 == n_paths, 1'b0);
        push_byte(CtrlUi);
        push_byte(PidNone);
    endtask

    task automatic push_path();
        if (n_paths >= MaxPathTb) phase = PH_REJECT;
        else
        begin
            addr_words[2+n_paths] = elem_addr();
            n_paths++;
        end
        clear_elem();
    endtask

    // Predicts the beats caused by one accepted character.
    task automatic predict_char(input logic [7:0] c, input logic eol);
        logic [15:0] f;
        case (phase)
            PH_SOURCE:
            begin
                if (c == ">")
                begin
                    if (!elem_used) phase = PH_REJECT;
                    else
                    begin
                        addr_words[1] = elem_addr();
                        phase = PH_DEST;
                    end
                    clear_elem();
                end
                else add_char(c);
            end
            PH_DEST:
            begin
                if (c == "," || c == ":")
                begin
                    if (!elem_used) phase = PH_REJECT;
                    else
                    begin
                        addr_words[0] = elem_addr();
                        if (c == ",") phase = PH_PATH;
                        else
                        begin
                            push_header();
                            phase = PH_INFO;
                        end
                    end
                    clear_elem();
                end
                else add_char(c);
            end
            PH_PATH:
            begin
                if (c == ",") push_path();
                else if (c == ":")
                begin
                    if (elem_used) push_path();
                    else clear_elem();
                    if (phase == PH_PATH)
                    begin
                        push_header();
                        phase = PH_INFO;
                    end
                end
                else add_char(c);
            end
            PH_INFO: push_byte(c);
            default: ;
        endcase
        if (eol)
        begin
            if (phase == PH_INFO)
            begin
                f = ~crc;
                queue_beat('{data: f[7:0], last: 1'b0, rej: 1'b0});
                queue_beat('{data: f[15:8], last: 1'b1, rej: 1'b0});
            end
            else queue_beat('{data: 8'h00, last: 1'b1, rej: 1'b1});
            clear_all();
        end
    endtask

    // Input beats feed the predictor, output beats are compared in order.
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            clear_all();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready) predict_char(char_in, end_of_line);
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat: actual byte %h end %b rej %b",
                             $time, frame_byte, frame_end, rejected);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.data !== frame_byte || want.last !== frame_end
                        || want.rej !== rejected)
                    begin
                        $display("%0t: mismatch: expected %h/%b/%b actual %h/%b/%b", $time,
                                 want.data, want.last, want.rej,
                                 frame_byte, frame_end, rejected);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the TNC2 to AX.25 frame encoder: drives TNC2 text lines
// and gives the verdict. Depends on tnc2_pkg, the encoder RTL and tb_frame_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_in;
    logic       end_of_line;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       rejected;
    int         fail_count;
    int         pending_count;
    logic       calm;
    logic       hold_off;
    logic       hold_done;
    int         sent_items;

    tnc2_to_ax25_frame_encoder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_in(char_in), .end_of_line(end_of_line),
        .out_valid(out_valid), .out_ready(out_ready),
        .frame_byte(frame_byte), .frame_end(frame_end), .rejected(rejected)
    );

    tb_frame_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_in(char_in), .end_of_line(end_of_line),
        .out_valid(out_valid), .out_ready(out_ready),
        .frame_byte(frame_byte), .frame_end(frame_end), .rejected(rejected),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls in bursts, one long hold-off, none at the end.
    initial
    begin
        int burst;
        out_ready = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !hold_done)
            begin
                out_ready <= 0;
                repeat (400) @(negedge clk);
                hold_done = 1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 11);
                out_ready <= 0;
                repeat (burst) @(negedge clk);
                out_ready <= 1;
            end
            else out_ready <= 1;
        end
    end

    // Sends one character and waits for its acceptance.
    task automatic send_char(input logic [7:0] c, input logic eol);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid <= 1;
        char_in <= c;
        end_of_line <= eol;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
        in_valid <= 0;
    endtask

    function automatic string rand_call();
        string s;
        int n;
        byte pool[] = '{"A", "z", "k", "0", "9", "Q", "m", "-", "W"};
        s = "";
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, 8)])};
        case ($urandom_range(0, 5))
            0: s = {s, "-", $sformatf("%0d", $urandom_range(0, 15))};
            1: s = {s, "-", $sformatf("%0d", $urandom_range(16, 999))};
            2: s = {s, "- -3"};
            3: s = {s, "-+7x"};
            default: ;
        endcase
        return s;
    endfunction

    function automatic string rand_line();
        string s;
        int np;
        s = {rand_call(), ">", rand_call()};
        np = $urandom_range(0, 7);
        for (int i = 0; i < np; i++) s = {s, ",", rand_call()};
        s = {s, ":"};
        for (int i = $urandom_range(0, 6); i > 0; i--)
            s = {s, string'(byte'($urandom_range(0, 255)))};
        return s;
    endfunction

    // Stimulus: directed lines, then random well-formed lines and noise.
    initial
    begin
        int wait_cycles;
        in_valid = 0;
        char_in = 0;
        end_of_line = 0;
        rst_n = 0;
        calm = 0;
        hold_off = 0;
        sent_items = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_line("N0CALL-7>APRS,WIDE1-1,WIDE2-2:hi");
        send_line("abcdefgh-99>dst-- 5,a,b,c,d,e,f:x");
        send_line("s>d,a,b,c,d,e,f,g:x");
        send_line(">d:x");
        send_line("s>:x");
        send_line("s>d,,:");
        send_line("a:b,c>d-\t+3:\377\000");
        send_line("s>d");
        send_line("x");

        // Keep offering while the receiver holds off.
        hold_off = 1;
        send_line("LONG>FILL,A,B,C,D,E,F:0123456789abcdef0123456789");
        send_line("K1>K2:z");

        while (sent_items < 360)
        begin
            if (sent_items > 300) calm = 1;
            if ($urandom_range(0, 9) == 0)
            begin
                string junk;
                junk = "";
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    junk = {junk, string'(byte'($urandom_range(0, 255)))};
                send_line(junk);
            end
            else send_line(rand_line());
        end

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        if (pending_count == 0 && fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
